// ----- rtl/core/xdts_pkg.sv -----
// shared types, constants and bit-count functions of the xor delta time series encoder
package xdts_pkg;

    localparam int CHUNK_W = 64;
    localparam int LEN_W = 7;
    localparam int HDR_W = 13;
    localparam int STR_W = CHUNK_W + HDR_W;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] MODE_HEAD = 2'd0;
    localparam logic [1:0] MODE_TIME = 2'd1;
    localparam logic [1:0] MODE_VALUE = 2'd2;

    localparam logic [HDR_W-1:0] DOD_HDR_SHORT = 13'h0002;
    localparam logic [HDR_W-1:0] DOD_HDR_MID = 13'h0006;
    localparam logic [HDR_W-1:0] DOD_HDR_LONG = 13'h000E;
    localparam logic [HDR_W-1:0] DOD_HDR_FULL = 13'h000F;
    localparam logic [HDR_W-1:0] VAL_HDR_REUSE = 13'h0002;
    localparam logic [1:0] VAL_TAG_NEW = 2'b11;

    localparam logic [6:0] LEAD_CAP = 7'd31;
    localparam logic [6:0] LEAD_RESET = 7'd64;

    typedef struct packed {
        logic [1:0] mode;
        logic [63:0] timestamp;
        logic [3:0] column;
        logic [63:0] value_bits;
    } in_item_t;

    typedef struct packed {
        logic [CHUNK_W-1:0] chunk;
        logic [LEN_W-1:0] chunk_length;
        logic last;
    } out_item_t;

    typedef enum logic [2:0] {
        CMD_HEAD,
        CMD_TS_FIRST,
        CMD_TS_DOD,
        CMD_VAL_RAW,
        CMD_VAL_XOR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        logic [3:0] col;
        logic [63:0] data;
    } cmd_t;

    typedef struct packed {
        logic [63:0] prev;
        logic [6:0] lead;
        logic [5:0] trail;
    } col_state_t;

    localparam col_state_t COL_STATE_RESET = '{prev: 64'd0, lead: LEAD_RESET, trail: 6'd0};

    function automatic logic [6:0] lead_zeros(input logic [63:0] x);
        logic [63:0] v;
        logic [6:0] c;
        begin
            v = x;
            c = 7'd0;
            if (x == 64'd0)
            begin
                return 7'd64;
            end
            if (v[63:32] == 32'd0)
            begin
                c = c + 7'd32;
                v = v << 32;
            end
            if (v[63:48] == 16'd0)
            begin
                c = c + 7'd16;
                v = v << 16;
            end
            if (v[63:56] == 8'd0)
            begin
                c = c + 7'd8;
                v = v << 8;
            end
            if (v[63:60] == 4'd0)
            begin
                c = c + 7'd4;
                v = v << 4;
            end
            if (v[63:62] == 2'd0)
            begin
                c = c + 7'd2;
                v = v << 2;
            end
            if (!v[63])
            begin
                c = c + 7'd1;
            end
            return c;
        end
    endfunction

    function automatic logic [6:0] trail_zeros(input logic [63:0] x);
        logic [63:0] r;
        begin
            for (int i = 0; i < 64; i++)
            begin
                r[i] = x[63-i];
            end
            return lead_zeros(r);
        end
    endfunction

endpackage

// ----- rtl/core/xdts_ram.sv -----
// generic single write port ram with registered read
module xdts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/xdts_front.sv -----
// front end: accepts items, keeps the time state and classifies items into commands
module xdts_front #(
    parameter int NUM_COLUMNS = 16,
    parameter int FIRST_DELTA_BITS = 14
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              full,
    input  xdts_pkg::in_item_t item,
    output logic              cmd_valid,
    output xdts_pkg::cmd_t    cmd
);

    import xdts_pkg::*;

    localparam logic [31:0] FD_MASK = 32'hFFFF_FFFF >> (32 - FIRST_DELTA_BITS);

    logic [31:0] head_reg, head_next;
    logic [31:0] last_reg, last_next;
    logic [31:0] prior_reg, prior_next;
    logic first_row_reg, first_row_next;
    logic row_seen_reg, row_seen_next;

    logic accept;
    logic [31:0] ts32;
    logic [31:0] first_delta;
    logic [31:0] dod;
    logic col_ok;

    always_comb
    begin
        accept = push && !full;
        ts32 = item.timestamp[31:0];
        first_delta = (ts32 - head_reg) & FD_MASK;
        dod = ts32 - last_reg - last_reg + prior_reg;
        col_ok = 32'(item.column) < 32'(NUM_COLUMNS);

        head_next = head_reg;
        last_next = last_reg;
        prior_next = prior_reg;
        first_row_next = first_row_reg;
        row_seen_next = row_seen_reg;
        cmd_valid = 1'b0;
        cmd = '{kind: CMD_HEAD, col: item.column, data: item.timestamp};

        if (accept)
        begin
            case (item.mode)
                MODE_HEAD:
                begin
                    cmd_valid = 1'b1;
                    head_next = ts32;
                    last_next = ts32;
                    prior_next = 32'd0;
                    first_row_next = 1'b1;
                    row_seen_next = 1'b0;
                end
                MODE_TIME:
                begin
                    cmd_valid = 1'b1;
                    if (!row_seen_reg)
                    begin
                        cmd.kind = CMD_TS_FIRST;
                        cmd.data = {32'd0, first_delta};
                        prior_next = head_reg;
                        row_seen_next = 1'b1;
                    end
                    else
                    begin
                        cmd.kind = CMD_TS_DOD;
                        cmd.data = {32'd0, dod};
                        prior_next = last_reg;
                        first_row_next = 1'b0;
                    end
                    last_next = ts32;
                end
                MODE_VALUE:
                begin
                    cmd_valid = col_ok;
                    cmd.kind = first_row_reg ? CMD_VAL_RAW : CMD_VAL_XOR;
                    cmd.data = item.value_bits;
                end
                default:
                begin
                    cmd_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= 32'd0;
            last_reg <= 32'd0;
            prior_reg <= 32'd0;
            first_row_reg <= 1'b1;
            row_seen_reg <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            last_reg <= last_next;
            prior_reg <= prior_next;
            first_row_reg <= first_row_next;
            row_seen_reg <= row_seen_next;
        end
    end

endmodule

// ----- rtl/core/xdts_cmd_queue.sv -----
// short command queue between front end and back end
module xdts_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  xdts_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output xdts_pkg::cmd_t head
);

    import xdts_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        begin
            return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
        end
    endfunction

    always_comb
    begin
        full = count_reg == CNT_W'(QUEUE_DEPTH);
        empty = count_reg == '0;
        head = entries_reg[rd_ptr_reg];
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- rtl/core/xdts_back.sv -----
// back end: column state memory, xor and delta encoding, bit string assembly and chunk output
module xdts_back #(
    parameter int NUM_COLUMNS = 16,
    parameter int FIRST_DELTA_BITS = 14
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  xdts_pkg::cmd_t     q_head,
    output logic               q_pop,
    output logic               sweep_busy,
    output logic               empty,
    input  logic               pop,
    output xdts_pkg::out_item_t result
);

    import xdts_pkg::*;

    localparam int ADDR_W = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
    localparam int STATE_W = $bits(col_state_t);

    // pipeline control
    logic en;
    logic issue;
    logic sweep_start;
    logic b_write;

    // issue stage
    logic b_valid_reg, b_valid_next;
    cmd_t b_cmd_reg;
    logic [ADDR_W-1:0] b_addr_reg;

    // column state memory and bypass
    logic ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    col_state_t ram_wr_data;
    col_state_t ram_rd_data;
    logic fwd_valid_reg, fwd_valid_next;
    logic [ADDR_W-1:0] fwd_addr_reg;
    col_state_t fwd_state_reg;
    logic sweep_active_reg, sweep_active_next;
    logic [ADDR_W-1:0] sweep_addr_reg, sweep_addr_next;

    // encode stage
    col_state_t cur_state;
    col_state_t new_state;
    logic [63:0] xr;
    logic [6:0] lz, tz;
    logic [4:0] cl;
    logic [6:0] sig;
    logic [7:0] win_sum;
    logic reuse;
    logic [31:0] zz;
    logic [63:0] c_x_next;
    logic [5:0] c_sh_next;
    logic [6:0] c_w_next;
    logic [HDR_W-1:0] c_hdr_next;
    logic [3:0] c_hlen_next;
    logic c_raw_next;

    // assembly stage
    logic c_valid_reg, c_valid_next;
    logic [63:0] c_x_reg;
    logic [5:0] c_sh_reg;
    logic [6:0] c_w_reg;
    logic [HDR_W-1:0] c_hdr_reg;
    logic [3:0] c_hlen_reg;
    logic c_raw_reg;
    logic [STR_W-1:0] e_string_next;
    logic [LEN_W-1:0] e_length_next;

    // output stage
    logic e_valid_reg, e_valid_next;
    logic e_second_reg, e_second_next;
    logic [STR_W-1:0] e_string_reg;
    logic [LEN_W-1:0] e_length_reg;
    logic e_split;
    logic [LEN_W-1:0] rest_len;
    logic [3:0] rest_shift;

    xdts_ram #(
        .WIDTH (STATE_W),
        .DEPTH (NUM_COLUMNS),
        .ADDR_W(ADDR_W)
    ) u_state_ram (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_en  (issue),
        .rd_addr(ADDR_W'(q_head.col)),
        .rd_data(ram_rd_data)
    );

    // output stage and stall
    always_comb
    begin
        e_split = e_length_reg > LEN_W'(CHUNK_W);
        rest_len = e_length_reg - LEN_W'(CHUNK_W);
        rest_shift = rest_len[3:0];
        empty = !e_valid_reg;
        result.chunk = e_string_reg[CHUNK_W-1:0];
        result.chunk_length = e_length_reg;
        result.last = 1'b1;
        if (e_split && !e_second_reg)
        begin
            result.chunk = CHUNK_W'(e_string_reg >> rest_shift);
            result.chunk_length = LEN_W'(CHUNK_W);
            result.last = 1'b0;
        end
        else if (e_split)
        begin
            result.chunk = e_string_reg[CHUNK_W-1:0] & ~({CHUNK_W{1'b1}} << rest_shift);
            result.chunk_length = rest_len;
        end

        en = !e_valid_reg || (pop && (!e_split || e_second_reg));
        e_valid_next = e_valid_reg;
        e_second_next = e_second_reg;
        if (en)
        begin
            e_valid_next = c_valid_reg;
            e_second_next = 1'b0;
        end
        else if (pop && e_split)
        begin
            e_second_next = 1'b1;
        end
    end

    // issue, memory write and clearing sweep
    always_comb
    begin
        sweep_busy = sweep_active_reg;
        issue = en && !q_empty && !sweep_active_reg &&
                !(b_valid_reg && (b_cmd_reg.kind == CMD_HEAD));
        q_pop = issue;
        b_valid_next = en ? issue : b_valid_reg;
        c_valid_next = en ? b_valid_reg : c_valid_reg;
        sweep_start = en && b_valid_reg && (b_cmd_reg.kind == CMD_HEAD);
        b_write = en && b_valid_reg &&
                  ((b_cmd_reg.kind == CMD_VAL_RAW) || (b_cmd_reg.kind == CMD_VAL_XOR));

        sweep_active_next = sweep_active_reg;
        sweep_addr_next = sweep_addr_reg;
        if (sweep_active_reg)
        begin
            if (sweep_addr_reg == ADDR_W'(NUM_COLUMNS - 1))
            begin
                sweep_active_next = 1'b0;
                sweep_addr_next = '0;
            end
            else
            begin
                sweep_addr_next = sweep_addr_reg + 1'b1;
            end
        end
        else if (sweep_start)
        begin
            sweep_active_next = 1'b1;
            sweep_addr_next = '0;
        end

        fwd_valid_next = fwd_valid_reg;
        if (sweep_start)
        begin
            fwd_valid_next = 1'b0;
        end
        else if (b_write)
        begin
            fwd_valid_next = 1'b1;
        end

        if (sweep_active_reg)
        begin
            ram_wr_en = 1'b1;
            ram_wr_addr = sweep_addr_reg;
            ram_wr_data = COL_STATE_RESET;
        end
        else
        begin
            ram_wr_en = b_write;
            ram_wr_addr = b_addr_reg;
            ram_wr_data = new_state;
        end
    end

    // encode stage
    always_comb
    begin
        cur_state = (fwd_valid_reg && (fwd_addr_reg == b_addr_reg)) ? fwd_state_reg : ram_rd_data;
        xr = b_cmd_reg.data ^ cur_state.prev;
        lz = lead_zeros(xr);
        tz = trail_zeros(xr);
        cl = (lz > LEAD_CAP) ? LEAD_CAP[4:0] : lz[4:0];
        sig = 7'd64 - {2'b00, cl} - tz;
        win_sum = {1'b0, cur_state.lead} + {2'b00, cur_state.trail};
        reuse = (lz >= cur_state.lead) && (tz >= {1'b0, cur_state.trail}) && (win_sum < 8'd64);
        zz = {b_cmd_reg.data[30:0], 1'b0} ^ {32{b_cmd_reg.data[31]}};

        c_x_next = b_cmd_reg.data;
        c_sh_next = 6'd0;
        c_w_next = 7'd64;
        c_hdr_next = '0;
        c_hlen_next = 4'd0;
        c_raw_next = 1'b0;
        new_state = '{prev: b_cmd_reg.data, lead: cur_state.lead, trail: cur_state.trail};

        case (b_cmd_reg.kind)
            CMD_HEAD:
            begin
                c_w_next = 7'd64;
            end
            CMD_TS_FIRST:
            begin
                c_w_next = 7'(FIRST_DELTA_BITS);
            end
            CMD_TS_DOD:
            begin
                c_x_next = {32'd0, zz};
                if (zz == 32'd0)
                begin
                    c_w_next = 7'd0;
                    c_hlen_next = 4'd1;
                end
                else if (zz[31:12] != 20'd0)
                begin
                    c_w_next = 7'd32;
                    c_hdr_next = DOD_HDR_FULL;
                    c_hlen_next = 4'd4;
                end
                else if (zz[31:9] != 23'd0)
                begin
                    c_w_next = 7'd12;
                    c_hdr_next = DOD_HDR_LONG;
                    c_hlen_next = 4'd4;
                end
                else if (zz[31:7] != 25'd0)
                begin
                    c_w_next = 7'd9;
                    c_hdr_next = DOD_HDR_MID;
                    c_hlen_next = 4'd3;
                end
                else
                begin
                    c_w_next = 7'd7;
                    c_hdr_next = DOD_HDR_SHORT;
                    c_hlen_next = 4'd2;
                end
            end
            CMD_VAL_RAW:
            begin
                c_raw_next = 1'b1;
            end
            CMD_VAL_XOR:
            begin
                c_x_next = xr;
                if (xr == 64'd0)
                begin
                    c_w_next = 7'd0;
                    c_hlen_next = 4'd1;
                end
                else if (reuse)
                begin
                    c_sh_next = cur_state.trail;
                    c_w_next = 7'd64 - cur_state.lead - {1'b0, cur_state.trail};
                    c_hdr_next = VAL_HDR_REUSE;
                    c_hlen_next = 4'd2;
                end
                else
                begin
                    c_sh_next = tz[5:0];
                    c_w_next = sig;
                    c_hdr_next = {VAL_TAG_NEW, cl, sig[5:0]};
                    c_hlen_next = 4'd13;
                    new_state.lead = {2'b00, cl};
                    new_state.trail = tz[5:0];
                end
            end
            default:
            begin
                c_w_next = 7'd64;
            end
        endcase
    end

    // assembly stage
    always_comb
    begin
        if (c_raw_reg)
        begin
            e_string_next = {{(STR_W - CHUNK_W - 1){1'b0}}, c_x_reg, 1'b0};
            e_length_next = LEN_W'(CHUNK_W + 1);
        end
        else
        begin
            e_string_next = ({{(STR_W - HDR_W){1'b0}}, c_hdr_reg} << c_w_reg) |
                            STR_W'(c_x_reg >> c_sh_reg);
            e_length_next = {3'b000, c_hlen_reg} + c_w_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            e_second_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
            sweep_active_reg <= 1'b1;
            sweep_addr_reg <= '0;
        end
        else
        begin
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
            e_valid_reg <= e_valid_next;
            e_second_reg <= e_second_next;
            fwd_valid_reg <= fwd_valid_next;
            sweep_active_reg <= sweep_active_next;
            sweep_addr_reg <= sweep_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            b_cmd_reg <= q_head;
            b_addr_reg <= ADDR_W'(q_head.col);
        end
        if (b_write)
        begin
            fwd_addr_reg <= b_addr_reg;
            fwd_state_reg <= new_state;
        end
        if (en)
        begin
            c_x_reg <= c_x_next;
            c_sh_reg <= c_sh_next;
            c_w_reg <= c_w_next;
            c_hdr_reg <= c_hdr_next;
            c_hlen_reg <= c_hlen_next;
            c_raw_reg <= c_raw_next;
            e_string_reg <= e_string_next;
            e_length_reg <= e_length_next;
        end
    end

endmodule

// ----- rtl/core/xor_delta_time_series_encoder_core.sv -----
// top level of the xor delta time series encoder
//
//  channel   handshake              payload
//  input     push / full            item   (mode, timestamp, column, value_bits)
//  result    empty / pop            result (chunk, chunk_length, last)
//
// an accepted item passes the command queue and the issue, assembly and output stages
// before its first chunk shows. the output register holds one item's chunks: up to 64
// bits leave as one chunk, a longer item as two, and the next item enters once the
// register is empty or its last chunk is popped. after reset and every head item the
// column state memory is cleared, one column a cycle, while full stays high.
// a stalled pop holds the back end; the command queue keeps taking items until full.
module xor_delta_time_series_encoder_core #(
    parameter int NUM_COLUMNS = 16,
    parameter int FIRST_DELTA_BITS = 14
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  xdts_pkg::in_item_t  item,
    output logic                empty,
    input  logic                pop,
    output xdts_pkg::out_item_t result
);

    import xdts_pkg::*;

    logic q_push;
    cmd_t q_push_cmd;
    logic q_full;
    logic q_pop;
    logic q_empty;
    cmd_t q_head;
    logic sweep_busy;

    assign full = q_full || sweep_busy;

    xdts_front #(
        .NUM_COLUMNS     (NUM_COLUMNS),
        .FIRST_DELTA_BITS(FIRST_DELTA_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .cmd_valid(q_push),
        .cmd      (q_push_cmd)
    );

    xdts_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_cmd(q_push_cmd),
        .full    (q_full),
        .pop     (q_pop),
        .empty   (q_empty),
        .head    (q_head)
    );

    xdts_back #(
        .NUM_COLUMNS     (NUM_COLUMNS),
        .FIRST_DELTA_BITS(FIRST_DELTA_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .sweep_busy(sweep_busy),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("command pushed into a full queue");

    a_no_issue_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        sweep_busy |-> !q_pop)
        else $error("command issued while column state is being cleared");

    a_chunk_length: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.chunk_length != 7'd0 && result.chunk_length <= 7'd64))
        else $error("chunk length out of range");

    a_second_chunk_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !result.last) |=> (!empty && result.last))
        else $error("second chunk of a transaction not ready after the first");

endmodule
